@@ src/plat_pkg.sv @@
// Shared constants, codes and the CORDIC arctangent table of the polyline accumulator.
package plat_pkg;

  localparam int HEAD_W     = 20;
  localparam int LEN_W      = 48;
  localparam int ANG_W      = 40;
  localparam int CFG_IDX_W  = 1;
  localparam int CXY_W      = 35;   // CORDIC x/y datapath width
  localparam int ZW         = 37;   // CORDIC angle accumulator, signed Q32 radians
  localparam int NORM_TOP   = 30;   // bit that holds the leading one after normalizing
  localparam int ANG_Q16_W  = 18;   // one rounded turn, Q16 radians, at most pi

  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [ANG_W-1:0] ANG_MAX = '1;
  localparam logic signed [ZW-1:0] PI_Q32 = 37'sd13493037705;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_HEADING = 1'b0,
    REG_GOAL_HEADING  = 1'b1
  } cfg_reg_e;

  // atan(2^-i) in Q32 radians, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_q32(input logic [5:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      6'd0:    r = 37'sd3373259426;
      6'd1:    r = 37'sd1991351318;
      6'd2:    r = 37'sd1052175346;
      6'd3:    r = 37'sd534100635;
      6'd4:    r = 37'sd268086748;
      6'd5:    r = 37'sd134174063;
      6'd6:    r = 37'sd67103403;
      6'd7:    r = 37'sd33553749;
      6'd8:    r = 37'sd16777131;
      6'd9:    r = 37'sd8388597;
      6'd10:   r = 37'sd4194303;
      default: r = (i <= 6'd32) ? (37'sd1 <<< (6'd32 - i)) : '0;
    endcase
    return r;
  endfunction

endpackage

@@ src/plat_point_if.sv @@
// Handshake channel that carries one path point.
interface plat_point_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          is_last;

  modport source(output valid, point_x, point_y, is_last, input ready);
  modport sink(input valid, point_x, point_y, is_last, output ready);
endinterface

@@ src/plat_result_if.sv @@
// Handshake channel that carries the path totals.
interface plat_result_if import plat_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] path_length;
  logic [ANG_W-1:0] turning_angle;
  logic             saturated;

  modport source(output valid, path_length, turning_angle, saturated, input ready);
  modport sink(input valid, path_length, turning_angle, saturated, output ready);
endinterface

@@ src/polyline_length_turn_accumulator.sv @@
// Top level: sequencer, shared multiplier and saturating accumulators of the polyline accumulator.
//
//  channel   | dir | payload                                   | accepted when
//  ----------+-----+-------------------------------------------+---------------------
//  point_i   | in  | point_x, point_y (signed Q15.16), is_last | valid & ready
//  result_o  | out | path_length, turning_angle, saturated     | valid & ready
//  cfg_*_i   | in  | register index, 20-bit heading            | cfg_we_i
//
// The first point of a path is only stored; if it is also the last, the heading and output
// states follow. Every later point passes the multiply steps and the square root, and
// where a turn is measured also the normalizer and the CORDIC rotations; the last point
// adds the heading and output states. The square root and the CORDIC loop take the longest.
// Reset is asynchronous and active low and clears the path state and both headings.
// A result waits in its output register while the next item is taken; the sequencer
// stalls only if a new result is ready while the previous one is still not taken.
module polyline_length_turn_accumulator import plat_pkg::*; #(
  parameter int COORD_WIDTH  = 32,
  parameter int CORDIC_STEPS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [HEAD_W-1:0]    cfg_data_i,
  plat_point_if.sink           point_i,
  plat_result_if.source        result_o
);

  localparam int DW   = COORD_WIDTH + 1;     // segment component width
  localparam int PRW  = 2 * DW;              // one product
  localparam int PW   = PRW + 1;             // dot or cross product
  localparam int SQW  = 2 * (DW + 1);        // squared length, even for the root unit
  localparam int RW   = SQW / 2;             // segment length width
  localparam int SUMW = ((RW > LEN_W) ? RW : LEN_W) + 1;
  localparam int AGW  = ANG_W + 1;

  // Multiply steps: which operands the shared multiplier sees.
  localparam logic [2:0] MS_DXX  = 3'd0;
  localparam logic [2:0] MS_DYY  = 3'd1;
  localparam logic [2:0] MS_DOTX = 3'd2;
  localparam logic [2:0] MS_DOTY = 3'd3;
  localparam logic [2:0] MS_CRSA = 3'd4;
  localparam logic [2:0] MS_CRSB = 3'd5;
  localparam logic [2:0] MS_LAST = 3'd6;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SQRT, S_TURN, S_HEAD, S_OUT} state_e;

  state_e                   state_q;
  logic signed [HEAD_W-1:0] start_heading_q, goal_heading_q;
  logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q;
  logic signed [DW-1:0]     prev_dx_q, prev_dy_q, dx_q, dy_q;
  logic [1:0]               pts_q;
  logic [LEN_W-1:0]         len_sum_q;
  logic [ANG_W-1:0]         ang_sum_q;
  logic                     sat_q, last_q, turn_q;
  logic [2:0]               mcnt_q;
  logic signed [PRW-1:0]    prod_q;
  logic [SQW-1:0]           sq_q;
  logic signed [PW-1:0]     dot_q, crs_q;
  logic                     out_valid_q, out_sat_q;
  logic [LEN_W-1:0]         out_len_q;
  logic [ANG_W-1:0]         out_ang_q;

  logic signed [DW-1:0]     dx_in, dy_in, mul_a, mul_b;
  logic signed [PRW-1:0]    mul_p;
  logic signed [PW-1:0]     prod_ext;
  logic                     accept, out_free;
  logic                     sqrt_start, sqrt_done, cordic_start, cordic_done;
  logic [RW-1:0]            seg_len;
  logic [ANG_Q16_W-1:0]     turn_ang;
  logic signed [HEAD_W:0]   head_diff;
  logic [HEAD_W:0]          head_abs;
  logic [SUMW-1:0]          len_add;
  logic [AGW-1:0]           ang_add, ang_inc;
  logic                     len_hit, ang_hit;

  assign point_i.ready = (state_q == S_IDLE);
  assign accept        = point_i.valid && point_i.ready;
  assign out_free      = !out_valid_q || result_o.ready;

  assign dx_in = {point_i.point_x[COORD_WIDTH-1], point_i.point_x}
               - {prev_x_q[COORD_WIDTH-1], prev_x_q};
  assign dy_in = {point_i.point_y[COORD_WIDTH-1], point_i.point_y}
               - {prev_y_q[COORD_WIDTH-1], prev_y_q};

  // One signed multiplier serves the two squares, the dot and the cross product.
  always_comb begin
    case (mcnt_q)
      MS_DXX:  begin mul_a = dx_q;      mul_b = dx_q; end
      MS_DYY:  begin mul_a = dy_q;      mul_b = dy_q; end
      MS_DOTX: begin mul_a = prev_dx_q; mul_b = dx_q; end
      MS_DOTY: begin mul_a = prev_dy_q; mul_b = dy_q; end
      MS_CRSA: begin mul_a = prev_dx_q; mul_b = dy_q; end
      MS_CRSB: begin mul_a = prev_dy_q; mul_b = dx_q; end
      default: begin mul_a = '0;        mul_b = '0;   end
    endcase
  end
  assign mul_p    = mul_a * mul_b;
  assign prod_ext = {prod_q[PRW-1], prod_q};

  assign sqrt_start   = (state_q == S_MUL) && (mcnt_q == MS_LAST);
  assign cordic_start = (state_q == S_SQRT) && sqrt_done && turn_q;

  plat_isqrt #(.NW(SQW)) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sq_q),
    .done_o     (sqrt_done),
    .root_o     (seg_len)
  );

  plat_cordic #(.PW(PW), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .dot_i   (dot_q),
    .crs_i   (crs_q),
    .done_o  (cordic_done),
    .angle_o (turn_ang)
  );

  // Heading difference is exact; both sums saturate once they reach their maximum.
  assign head_diff = {start_heading_q[HEAD_W-1], start_heading_q}
                   - {goal_heading_q[HEAD_W-1], goal_heading_q};
  assign head_abs  = head_diff[HEAD_W] ? $unsigned(-head_diff) : $unsigned(head_diff);
  assign len_add   = SUMW'(len_sum_q) + SUMW'(seg_len);
  assign len_hit   = len_add >= SUMW'(LEN_MAX);
  assign ang_inc   = (state_q == S_HEAD) ? AGW'(head_abs) : AGW'(turn_ang);
  assign ang_add   = AGW'(ang_sum_q) + ang_inc;
  assign ang_hit   = ang_add >= AGW'(ANG_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_heading_q <= '0;
      goal_heading_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_START_HEADING: start_heading_q <= $signed(cfg_data_i);
        REG_GOAL_HEADING:  goal_heading_q  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_dx_q   <= '0;
      prev_dy_q   <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      pts_q       <= '0;
      len_sum_q   <= '0;
      ang_sum_q   <= '0;
      sat_q       <= 1'b0;
      last_q      <= 1'b0;
      turn_q      <= 1'b0;
      mcnt_q      <= '0;
      prod_q      <= '0;
      sq_q        <= '0;
      dot_q       <= '0;
      crs_q       <= '0;
      out_valid_q <= 1'b0;
      out_len_q   <= '0;
      out_ang_q   <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      // The output register loads in the output state and empties when taken.
      out_valid_q <= ((state_q == S_OUT) && out_free) || (out_valid_q && !result_o.ready);
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            prev_x_q <= point_i.point_x;
            prev_y_q <= point_i.point_y;
            last_q   <= point_i.is_last;
            dx_q     <= dx_in;
            dy_q     <= dy_in;
            mcnt_q   <= MS_DXX;
            // A turn is measured only between two segments of nonzero length.
            turn_q   <= (pts_q == 2'd2) && ((prev_dx_q != '0) || (prev_dy_q != '0))
                        && ((dx_in != '0) || (dy_in != '0));
            if (pts_q != 2'd2) begin
              pts_q <= pts_q + 1'b1;
            end
            if (pts_q != 2'd0) begin
              state_q <= S_MUL;
            end else if (point_i.is_last) begin
              state_q <= S_HEAD;
            end
          end
        end
        S_MUL: begin
          prod_q <= mul_p;
          mcnt_q <= mcnt_q + 1'b1;
          case (mcnt_q)
            MS_DYY:  sq_q  <= {2'b00, $unsigned(prod_q)};
            MS_DOTX: sq_q  <= sq_q + {2'b00, $unsigned(prod_q)};
            MS_DOTY: dot_q <= prod_ext;
            MS_CRSA: dot_q <= dot_q + prod_ext;
            MS_CRSB: crs_q <= prod_ext;
            MS_LAST: crs_q <= crs_q - prod_ext;
            default: ;
          endcase
          if (mcnt_q == MS_LAST) begin
            prev_dx_q <= dx_q;
            prev_dy_q <= dy_q;
            state_q   <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            if (len_hit) begin
              len_sum_q <= LEN_MAX;
              sat_q     <= 1'b1;
            end else begin
              len_sum_q <= len_add[LEN_W-1:0];
            end
            if (turn_q) begin
              state_q <= S_TURN;
            end else begin
              state_q <= last_q ? S_HEAD : S_IDLE;
            end
          end
        end
        S_TURN: begin
          if (cordic_done) begin
            if (ang_hit) begin
              ang_sum_q <= ANG_MAX;
              sat_q     <= 1'b1;
            end else begin
              ang_sum_q <= ang_add[ANG_W-1:0];
            end
            state_q <= last_q ? S_HEAD : S_IDLE;
          end
        end
        S_HEAD: begin
          if (ang_hit) begin
            ang_sum_q <= ANG_MAX;
            sat_q     <= 1'b1;
          end else begin
            ang_sum_q <= ang_add[ANG_W-1:0];
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_len_q   <= len_sum_q;
            out_ang_q   <= ang_sum_q;
            out_sat_q   <= sat_q;
            prev_x_q    <= '0;
            prev_y_q    <= '0;
            prev_dx_q   <= '0;
            prev_dy_q   <= '0;
            pts_q       <= '0;
            len_sum_q   <= '0;
            ang_sum_q   <= '0;
            sat_q       <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.path_length   = out_len_q;
  assign result_o.turning_angle = out_ang_q;
  assign result_o.saturated     = out_sat_q;

  // The root unit reports only while the sequencer waits for it.
  a_sqrt_in_place : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == S_SQRT)
    else $error("square root finished outside its wait state");

  // The CORDIC unit reports only while a turn is being measured.
  a_cordic_in_place : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_done |-> state_q == S_TURN)
    else $error("CORDIC finished outside its wait state");

  // A new result is only ever loaded from the output state.
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result appeared without passing the output state");

  // The path state is cleared once the result leaves the output state.
  a_path_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (pts_q == 2'd0 && len_sum_q == '0 && !sat_q))
    else $error("path state not cleared after a result");

endmodule

@@ src/plat_isqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle.
module plat_isqrt #(
  parameter int NW = 68
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NW-1:0]   radicand_i,
  output logic            done_o,
  output logic [NW/2-1:0] root_o
);

  localparam int RW   = NW / 2;
  localparam int REMW = RW + 3;
  localparam int CNTW = $clog2(RW + 1);

  logic [NW-1:0]   rad_q;
  logic [REMW-1:0] rem_q;
  logic [RW-1:0]   root_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [REMW-1:0] rem_next, trial;
  logic            fits;

  assign rem_next = {rem_q[REMW-3:0], rad_q[NW-1:NW-2]};
  assign trial    = REMW'({root_q, 2'b01});
  assign fits     = rem_next >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CNTW'(1));
      if (start_i) begin
        rad_q  <= radicand_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= CNTW'(RW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rad_q  <= rad_q << 2;
        rem_q  <= fits ? rem_next - trial : rem_next;
        root_q <= {root_q[RW-2:0], fits};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ src/plat_cordic.sv @@
// Normalizer and vectoring CORDIC that turn a dot and cross product into a turn angle.
module plat_cordic import plat_pkg::*; #(
  parameter int PW           = 67,
  parameter int CORDIC_STEPS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [PW-1:0] dot_i,
  input  logic signed [PW-1:0] crs_i,
  output logic                 done_o,
  output logic [ANG_Q16_W-1:0] angle_o
);

  localparam int MW = (PW > 40) ? PW : 40;
  localparam int IW = $clog2(CORDIC_STEPS);

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ROT, C_FIN} cstate_e;

  cstate_e                state_q;
  logic [MW-1:0]          dm_q, cm_q;
  logic                   dneg_q, done_q;
  logic signed [CXY_W-1:0] x_q, y_q;
  logic signed [ZW-1:0]   z_q;
  logic [IW-1:0]          i_q;
  logic [ANG_Q16_W-1:0]   angle_q;

  logic [PW-1:0]          dot_abs, crs_abs;
  logic [MW-1:0]          mor;
  logic signed [CXY_W-1:0] xs, ys;
  logic signed [ZW-1:0]   at, zf, zc, zr;

  assign dot_abs = dot_i[PW-1] ? $unsigned(-dot_i) : $unsigned(dot_i);
  assign crs_abs = crs_i[PW-1] ? $unsigned(-crs_i) : $unsigned(crs_i);
  assign mor     = dm_q | cm_q;
  assign xs      = x_q >>> i_q;
  assign ys      = y_q >>> i_q;
  assign at      = atan_q32(6'(i_q));

  // An obtuse turn folds back around pi, then the angle is clamped and rounded to Q16.
  always_comb begin
    zf = dneg_q ? PI_Q32 - z_q : z_q;
    if (zf < 0) begin
      zc = '0;
    end else if (zf > PI_Q32) begin
      zc = PI_Q32;
    end else begin
      zc = zf;
    end
    zr = zc + 37'sd32768;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      dm_q    <= '0;
      cm_q    <= '0;
      dneg_q  <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      i_q     <= '0;
      done_q  <= 1'b0;
      angle_q <= '0;
    end else begin
      done_q <= (state_q == C_FIN);
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            dm_q   <= MW'(dot_abs);
            cm_q   <= MW'(crs_abs);
            dneg_q <= dot_i[PW-1];
            z_q    <= '0;
            i_q    <= '0;
            state_q <= ((dot_abs | crs_abs) == '0) ? C_FIN : C_NORM;
          end
        end
        C_NORM: begin
          if (|mor[MW-1:NORM_TOP+9]) begin
            dm_q <= dm_q >> 8;
            cm_q <= cm_q >> 8;
          end else if (|mor[MW-1:NORM_TOP+1]) begin
            dm_q <= dm_q >> 1;
            cm_q <= cm_q >> 1;
          end else if (mor[NORM_TOP:NORM_TOP-7] == '0) begin
            dm_q <= dm_q << 8;
            cm_q <= cm_q << 8;
          end else if (!mor[NORM_TOP]) begin
            dm_q <= dm_q << 1;
            cm_q <= cm_q << 1;
          end else begin
            x_q     <= $signed(CXY_W'(dm_q[NORM_TOP:0]));
            y_q     <= $signed(CXY_W'(cm_q[NORM_TOP:0]));
            state_q <= C_ROT;
          end
        end
        C_ROT: begin
          if (y_q > 0) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + at;
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - at;
          end
          i_q <= i_q + 1'b1;
          if (i_q == IW'(CORDIC_STEPS - 1)) begin
            state_q <= C_FIN;
          end
        end
        C_FIN: begin
          angle_q <= zr[16 +: ANG_Q16_W];
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule

@@ tb/plat_tb_pkg.sv @@
`timescale 1ns / 100ps
// Path totals predictor and scoreboard class for the polyline accumulator bench.
package plat_tb_pkg;
  import plat_pkg::*;

  typedef struct packed {
    logic [LEN_W-1:0] path_length;
    logic [ANG_W-1:0] turning_angle;
    logic             saturated;
  } totals_t;

  class path_scoreboard;
    // Path state of the predictor.
    logic signed [63:0] last_x, last_y, last_dx, last_dy;
    int unsigned        seen;
    logic [LEN_W-1:0]   len_acc;
    logic [ANG_W-1:0]   ang_acc;
    bit                 sat;
    logic signed [63:0] head_start, head_goal;
    totals_t            pending_totals[$];
    int unsigned        mismatches;

    function new();
      head_start = 0;
      head_goal = 0;
      mismatches = 0;
      clear_path();
    endfunction

    function void clear_path();
      last_x = 0; last_y = 0; last_dx = 0; last_dy = 0;
      seen = 0; len_acc = 0; ang_acc = 0; sat = 0;
    endfunction

    function void set_heading(cfg_reg_e idx, logic [HEAD_W-1:0] val);
      if (idx == REG_START_HEADING) head_start = 64'(signed'(val));
      else head_goal = 64'(signed'(val));
    endfunction

    function logic [LEN_W-1:0] add_len(logic [LEN_W-1:0] acc, logic [127:0] v);
      if (acc == LEN_MAX || v >= 128'(LEN_MAX - acc)) begin
        sat = 1;
        return LEN_MAX;
      end
      return acc + v[LEN_W-1:0];
    endfunction

    function logic [ANG_W-1:0] add_ang(logic [ANG_W-1:0] acc, logic [63:0] v);
      if (acc == ANG_MAX || v >= 64'(ANG_MAX - acc)) begin
        sat = 1;
        return ANG_MAX;
      end
      return acc + v[ANG_W-1:0];
    endfunction

    // Bitwise integer square root of a 128-bit value.
    function logic [63:0] floor_sqrt(logic [127:0] n);
      logic [127:0] rem, trial;
      logic [63:0]  root;
      rem = 0;
      root = 0;
      for (int i = 63; i >= 0; i--) begin
        rem = (rem << 2) | ((n >> (2 * i)) & 128'd3);
        trial = ({64'd0, root} << 2) | 128'd1;
        if (rem >= trial) begin
          rem = rem - trial;
          root = (root << 1) | 64'd1;
        end else begin
          root = root << 1;
        end
      end
      return root;
    endfunction

    function logic signed [63:0] atan_entry(int i);
      case (i)
        0: return 64'sd3373259426;
        1: return 64'sd1991351318;
        2: return 64'sd1052175346;
        3: return 64'sd534100635;
        4: return 64'sd268086748;
        5: return 64'sd134174063;
        6: return 64'sd67103403;
        7: return 64'sd33553749;
        8: return 64'sd16777131;
        9: return 64'sd8388597;
        10: return 64'sd4194303;
        default: return (i <= 32) ? (64'sd1 <<< (32 - i)) : 64'sd0;
      endcase
    endfunction

    // Unsigned angle between two segments, Q16 radians, by vectoring CORDIC.
    function logic [63:0] vertex_turn(logic signed [63:0] ax, ay, bx, by);
      logic signed [127:0] dot, crs;
      logic [127:0]        ud, uc, um;
      logic signed [63:0]  x, y, z, xs, ys;
      bit                  dneg;
      int                  blen;
      dot = 128'(ax) * 128'(bx) + 128'(ay) * 128'(by);
      crs = 128'(ax) * 128'(by) - 128'(ay) * 128'(bx);
      dneg = dot < 0;
      ud = dneg ? -dot : dot;
      uc = crs < 0 ? -crs : crs;
      um = ud > uc ? ud : uc;
      blen = 0;
      for (int i = 0; i < 128; i++) if (um[i]) blen = i + 1;
      if (blen == 0) return 0;
      if (blen > 31) begin
        x = 64'(ud >> (blen - 31));
        y = 64'(uc >> (blen - 31));
      end else begin
        x = 64'(ud << (31 - blen));
        y = 64'(uc << (31 - blen));
      end
      z = 0;
      for (int i = 0; i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z = z + atan_entry(i);
        end else begin
          x = x - ys; y = y + xs; z = z - atan_entry(i);
        end
      end
      if (dneg) z = 64'(PI_Q32) - z;
      if (z < 0) z = 0;
      if (z > 64'(PI_Q32)) z = 64'(PI_Q32);
      return 64'(z + 32768) >> 16;
    endfunction

    // Notes one accepted point; queues the totals when it ends a path.
    function void note_point(logic signed [31:0] px, py, bit last);
      logic signed [63:0] x, y, dx, dy, hd;
      logic [127:0]       sq;
      x = 64'(px);
      y = 64'(py);
      if (seen >= 1) begin
        dx = x - last_x;
        dy = y - last_y;
        sq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
        len_acc = add_len(len_acc, 128'(floor_sqrt(sq)));
        if (seen >= 2 && (last_dx != 0 || last_dy != 0) && (dx != 0 || dy != 0))
          ang_acc = add_ang(ang_acc, vertex_turn(last_dx, last_dy, dx, dy));
        last_dx = dx;
        last_dy = dy;
      end
      if (seen < 2) seen++;
      last_x = x;
      last_y = y;
      if (last) begin
        hd = head_start - head_goal;
        ang_acc = add_ang(ang_acc, hd < 0 ? -hd : hd);
        pending_totals.push_back(totals_t'{len_acc, ang_acc, sat});
        clear_path();
      end
    endfunction

    function void check_totals(totals_t got);
      totals_t want;
      if (pending_totals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected totals: len %0d ang %0d sat %0d",
                   got.path_length, got.turning_angle, got.saturated);
        return;
      end
      want = pending_totals.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("totals differ: len %0d/%0d ang %0d/%0d sat %0d/%0d (want/got)",
                   want.path_length, got.path_length, want.turning_angle,
                   got.turning_angle, want.saturated, got.saturated);
      end
    endfunction
  endclass
endpackage

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Top level of the polyline accumulator bench: clock, reset, drivers and checks.
module tb_top;
  import plat_pkg::*;
  import plat_tb_pkg::*;

  localparam int DRAIN_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 20000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [HEAD_W-1:0] cfg_data_i = '0;

  plat_point_if #(.COORD_WIDTH(32)) point_ch();
  plat_result_if result_ch();

  polyline_length_turn_accumulator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .point_i(point_ch.sink), .result_o(result_ch.source)
  );

  path_scoreboard totals_board = new();

  // Idle percentage of the sender and stall percentage of the receiver.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // While set, the receiver holds ready low to back the block up.
  bit          hold_results = 1'b0;
  int unsigned quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  // Sampling at the rising edge: every accepted point and result goes to the board.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (point_ch.valid && point_ch.ready) begin
        totals_board.note_point(point_ch.point_x, point_ch.point_y, point_ch.is_last);
      end
      if (result_ch.valid && result_ch.ready) begin
        totals_board.check_totals(totals_t'{result_ch.path_length,
                                            result_ch.turning_angle,
                                            result_ch.saturated});
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // The receiver changes ready at the falling edge, stalling at random.
  always @(negedge clk_i) begin
    if (!rst_ni || hold_results) result_ch.ready <= 1'b0;
    else result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offers one point and waits until the block takes it.
  task automatic send_point(logic [31:0] px, logic [31:0] py, bit last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(negedge clk_i);
    point_ch.valid = 1'b1;
    point_ch.point_x <= px;
    point_ch.point_y <= py;
    point_ch.is_last <= last;
    @(posedge clk_i);
    while (!point_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    point_ch.valid = 1'b0;
  endtask

  // Writes a heading register; only called while the block is idle.
  task automatic write_heading(cfg_reg_e idx, logic [HEAD_W-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    totals_board.set_heading(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Waits for all totals to come back, then for the block to fall quiet.
  task automatic drain();
    while (totals_board.pending_totals.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int unsigned mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      default: return 32'($signed($urandom_range(65536)) - 32768);
    endcase
  endfunction

  // A random path of a few points; mostly moderate coordinates, some full range,
  // with repeated points to hit zero-length segments.
  task automatic send_random_path(ref int unsigned sent);
    int unsigned npts, mode;
    logic [31:0] px, py;
    npts = $urandom_range(6, 1);
    mode = $urandom_range(3);
    px = rand_coord(mode);
    py = rand_coord(mode);
    for (int k = 0; k < npts; k++) begin
      if ($urandom_range(9) != 0 || k == 0) begin
        px = rand_coord(mode);
        py = rand_coord(mode);
      end
      send_point(px, py, k == npts - 1);
      sent++;
    end
  endtask

  initial begin
    int unsigned sent;
    sent = 0;
    point_ch.valid = 1'b0;
    point_ch.point_x = '0;
    point_ch.point_y = '0;
    point_ch.is_last = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part with headings at the reset value.
    send_point(32'h0, 32'h0, 1'b1);                     // single-point path
    send_point(32'h8000_0000, 32'h8000_0000, 1'b0);     // diagonal across the whole range
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b1);     // straight reversal, a turn of pi
    send_point(32'h0, 32'h0, 1'b0);
    send_point(32'h0, 32'h0, 1'b0);                     // zero-length segment
    send_point(32'h0001_0000, 32'h0, 1'b0);
    send_point(32'h0001_0000, 32'h0001_0000, 1'b0);     // right angle
    send_point(32'h0002_0000, 32'h0002_0000, 1'b0);     // diagonal step, a turn of pi/4
    send_point(32'h0002_0000, 32'h0002_0000, 1'b1);     // zero-length last segment
    drain();

    write_heading(REG_START_HEADING, 20'h7FFFF);
    write_heading(REG_GOAL_HEADING, 20'h80000);
    send_point(32'h0, 32'h0, 1'b1);                     // largest heading difference
    // Long back-and-forth run of full-range segments, with a turn of pi at each vertex.
    for (int k = 0; k < 12; k++)
      send_point((k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000, 32'h8000_0000, k == 11);
    drain();

    // Random part over the idle phases, with a heading setting per phase.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      if (phase == 7) begin
        write_heading(REG_START_HEADING, 20'h80000);
        write_heading(REG_GOAL_HEADING, 20'h80000);
      end else begin
        write_heading(REG_START_HEADING, 20'($urandom()));
        write_heading(REG_GOAL_HEADING, 20'($urandom()));
      end
      if (phase == 2) begin
        // The receiver holds off while single-point paths keep coming,
        // so the output register fills and the block stalls its input.
        fork
          begin
            hold_results = 1'b1;
            repeat (600) @(negedge clk_i);
            hold_results = 1'b0;
          end
          for (int k = 0; k < 8; k++) begin
            send_point($urandom(), $urandom(), 1'b1);
            sent++;
          end
        join
      end
      while (sent < (phase + 1) * 130) send_random_path(sent);
      drain();
    end

    if (totals_board.mismatches == 0 && totals_board.pending_totals.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
